### rtl/core/im2col_address_generator_macros.svh
// Assertion macros for the im2col address generator.
// They expect clk_i and rst_ni in scope.
`ifndef IM2COL_ADDRESS_GENERATOR_MACROS_SVH
`define IM2COL_ADDRESS_GENERATOR_MACROS_SVH

// Consequent must hold in the cycle the antecedent holds
`define IM2COL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("im2col check failed");

// Expression must hold on every clock edge out of reset
`define IM2COL_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("im2col check failed");

`endif

### rtl/core/im2col_pkg.sv
package im2col_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_KERNEL   = 3'd0;
  localparam logic [2:0] REG_PAD      = 3'd1;
  localparam logic [2:0] REG_STRIDE   = 3'd2;
  localparam logic [2:0] REG_WIDTH    = 3'd3;
  localparam logic [2:0] REG_HEIGHT   = 3'd4;
  localparam logic [2:0] REG_CHANNELS = 3'd5;

  // Item pipeline: ten stages of six restoring-division steps, then one output stage
  localparam int NUM_STAGES = 10;
  localparam int STEPS      = 6;
  localparam int DIV1_LAST  = 2;
  localparam int DIV2_LAST  = 5;
  localparam int LATENCY    = NUM_STAGES + 1;

  typedef struct packed {
    logic [3:0]  k;
    logic [3:0]  s;
    logic [3:0]  p;
    logic [12:0] w;
    logic [12:0] h;
    logic [10:0] c;
    logic [12:0] xs;
    logic [25:0] xy;
    logic [18:0] rowlim;
  } cfg_t;

  typedef struct packed {
    logic [23:0] col;
    logic [17:0] row;
    logic [23:0] num;
    logic [23:0] quo;
    logic [12:0] rem;
    logic [3:0]  dx;
    logic [3:0]  dy;
    logic [9:0]  dz;
  } stage_t;

  // One restoring step: returns {quotient bit, new remainder}
  function automatic logic [13:0] div_step(logic [12:0] rem, logic nb, logic [12:0] d);
    logic [13:0] t;
    logic [13:0] diff;
    t = {rem, nb};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {1'b1, diff[12:0]};
    end
    return {1'b0, t[12:0]};
  endfunction

endpackage

### rtl/core/im2col_cfg.sv
module im2col_cfg
  import im2col_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  output cfg_t        cfg_o
);

  logic [3:0]  kernel_q, pad_q, stride_q;
  logic [12:0] width_q, height_q;
  logic [10:0] chan_q;

  logic [3:0]  k_e, s_e;
  logic [12:0] w_e, h_e;
  logic [10:0] c_e;
  logic [13:0] pad_x, pad_y;

  // stage 1
  logic [3:0]  k1_q, s1_q, p1_q;
  logic [12:0] w1_q, h1_q, nx1_q, ny1_q;
  logic [10:0] c1_q;
  logic [7:0]  kk1_q;
  logic        fx1_q, fy1_q;
  // stages 2 and 3: placement division
  logic [12:0] nx2_q, ny2_q, qx2_q, qy2_q, rx2_q, ry2_q;
  logic [12:0] nx2_d, ny2_d, qx2_d, qy2_d, rx2_d, ry2_d;
  logic        fx2_q, fy2_q, fx3_q, fy3_q;
  logic [18:0] rowlim2_q;
  logic [12:0] qx3_q, qy3_q, qx3_d, qy3_d;
  // stages 4 and 5
  logic [12:0] xs4_q, ys4_q;
  logic [25:0] xy5_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_q <= 4'd3;
      pad_q    <= 4'd1;
      stride_q <= 4'd1;
      width_q  <= 13'd32;
      height_q <= 13'd32;
      chan_q   <= 11'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_KERNEL:   kernel_q <= cfg_data_i[3:0];
        REG_PAD:      pad_q    <= cfg_data_i[3:0];
        REG_STRIDE:   stride_q <= cfg_data_i[3:0];
        REG_WIDTH:    width_q  <= cfg_data_i;
        REG_HEIGHT:   height_q <= cfg_data_i;
        REG_CHANNELS: chan_q   <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    k_e = (kernel_q == 4'd0) ? 4'd1 : kernel_q;
    s_e = (stride_q == 4'd0) ? 4'd1 : stride_q;
    w_e = (width_q == 13'd0) ? 13'd1 : ((width_q > 13'd4096) ? 13'd4096 : width_q);
    h_e = (height_q == 13'd0) ? 13'd1 : ((height_q > 13'd4096) ? 13'd4096 : height_q);
    c_e = (chan_q == 11'd0) ? 11'd1 : ((chan_q > 11'd1024) ? 11'd1024 : chan_q);
    pad_x = {1'b0, w_e} + {9'd0, pad_q, 1'b0};
    pad_y = {1'b0, h_e} + {9'd0, pad_q, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    k1_q  <= k_e;
    s1_q  <= s_e;
    p1_q  <= pad_q;
    w1_q  <= w_e;
    h1_q  <= h_e;
    c1_q  <= c_e;
    kk1_q <= 8'(k_e * k_e);
    fx1_q <= pad_x >= {10'd0, k_e};
    fy1_q <= pad_y >= {10'd0, k_e};
    nx1_q <= 13'(pad_x - {10'd0, k_e});
    ny1_q <= 13'(pad_y - {10'd0, k_e});
  end

  // Placement count: seven steps, then six
  always_comb begin
    logic [13:0] r;
    nx2_d = nx1_q;
    ny2_d = ny1_q;
    qx2_d = '0;
    qy2_d = '0;
    rx2_d = '0;
    ry2_d = '0;
    for (int b = 0; b < 7; b++) begin
      r = div_step(rx2_d, nx2_d[12], {9'd0, s1_q});
      qx2_d = {qx2_d[11:0], r[13]};
      rx2_d = r[12:0];
      nx2_d = {nx2_d[11:0], 1'b0};
      r = div_step(ry2_d, ny2_d[12], {9'd0, s1_q});
      qy2_d = {qy2_d[11:0], r[13]};
      ry2_d = r[12:0];
      ny2_d = {ny2_d[11:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    nx2_q     <= nx2_d;
    ny2_q     <= ny2_d;
    qx2_q     <= qx2_d;
    qy2_q     <= qy2_d;
    rx2_q     <= rx2_d;
    ry2_q     <= ry2_d;
    fx2_q     <= fx1_q;
    fy2_q     <= fy1_q;
    rowlim2_q <= 19'({11'd0, kk1_q} * {8'd0, c1_q});
  end

  always_comb begin
    logic [13:0] r;
    logic [12:0] nx, ny, rx, ry;
    nx = nx2_q;
    ny = ny2_q;
    rx = rx2_q;
    ry = ry2_q;
    qx3_d = qx2_q;
    qy3_d = qy2_q;
    for (int b = 0; b < 6; b++) begin
      r = div_step(rx, nx[12], {9'd0, s1_q});
      qx3_d = {qx3_d[11:0], r[13]};
      rx = r[12:0];
      nx = {nx[11:0], 1'b0};
      r = div_step(ry, ny[12], {9'd0, s1_q});
      qy3_d = {qy3_d[11:0], r[13]};
      ry = r[12:0];
      ny = {ny[11:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    qx3_q <= qx3_d;
    qy3_q <= qy3_d;
    fx3_q <= fx2_q;
    fy3_q <= fy2_q;
    xs4_q <= fx3_q ? 13'(qx3_q + 13'd1) : 13'd0;
    ys4_q <= fy3_q ? 13'(qy3_q + 13'd1) : 13'd0;
    xy5_q <= 26'({13'd0, xs4_q} * {13'd0, ys4_q});
  end

  // kernel side is used by the first item stage, so it bypasses the chain
  always_comb begin
    cfg_o.k      = k_e;
    cfg_o.s      = s1_q;
    cfg_o.p      = p1_q;
    cfg_o.w      = w1_q;
    cfg_o.h      = h1_q;
    cfg_o.c      = c1_q;
    cfg_o.xs     = xs4_q;
    cfg_o.xy     = xy5_q;
    cfg_o.rowlim = rowlim2_q;
  end

endmodule

### rtl/core/im2col_address_generator.sv
// Channel  | Handshake               | Payload
// ---------+-------------------------+-----------------------------------------
// item in  | start, busy             | column_index_i, row_index_i
// result   | result_strobe_o         | source_x_o, source_y_o, source_channel_o,
//          |                         | inside_image_o, index_in_range_o
// config   | cfg_valid_i, cfg_ready_o| cfg_index_i, cfg_data_i
//
// One item per cycle while busy is low; each result leaves the output stage after the ten item stages.
// The pipeline holds ten stages of six restoring-division steps each
// (row by kernel side, twice, then column by placements per row) and an output stage.
// busy is high for one cycle after reset, then stays low. The receiver cannot stall.
// Derived configuration is rebuilt in the registered stages of im2col_cfg after a register write.
module im2col_address_generator
  import im2col_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [23:0]        column_index_i,
  input  logic [17:0]        row_index_i,
  output logic               result_strobe_o,
  output logic signed [13:0] source_x_o,
  output logic signed [13:0] source_y_o,
  output logic [9:0]         source_channel_o,
  output logic               inside_image_o,
  output logic               index_in_range_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [12:0]        cfg_data_i
);

  cfg_t   cfg;
  logic   busy_q;
  logic   accept;
  stage_t init;
  stage_t st_in [NUM_STAGES];
  stage_t st_d  [NUM_STAGES];
  stage_t st_q  [NUM_STAGES];
  logic [NUM_STAGES-1:0] v_q;

  logic               out_v_q, in_rng_q, in_img_q;
  logic signed [13:0] sx_q, sy_q;
  logic [9:0]         dz_q;

  logic [16:0]        px, py;
  logic signed [18:0] sx, sy;
  logic               in_rng, in_img;

  im2col_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign busy   = busy_q;
  assign accept = start && !busy_q;

  always_comb begin
    init     = '0;
    init.col = column_index_i;
    init.row = row_index_i;
    init.num = {row_index_i, 6'd0};
  end

  for (genvar j = 0; j < NUM_STAGES; j++) begin : g_stage
    if (j == 0) begin : g_first
      assign st_in[j] = init;
    end else begin : g_next
      assign st_in[j] = st_q[j-1];
    end

    always_comb begin
      stage_t      s;
      logic [13:0] r;
      logic [12:0] d;
      logic [9:0]  cm1;
      s   = st_in[j];
      d   = (j <= DIV2_LAST) ? {9'd0, cfg.k} : cfg.xs;
      cm1 = 10'(cfg.c - 11'd1);
      for (int b = 0; b < STEPS; b++) begin
        r     = div_step(s.rem, s.num[23], d);
        s.quo = {s.quo[22:0], r[13]};
        s.rem = r[12:0];
        s.num = {s.num[22:0], 1'b0};
      end
      // end of row / k: keep kernel x, divide the quotient again
      if (j == DIV1_LAST) begin
        s.dx  = s.rem[3:0];
        s.num = {s.quo[17:0], 6'd0};
        s.quo = '0;
        s.rem = '0;
      end
      // end of second division: kernel y and saturated channel, start on column
      if (j == DIV2_LAST) begin
        s.dy  = s.rem[3:0];
        s.dz  = (s.quo[17:0] > {8'd0, cm1}) ? cm1 : s.quo[9:0];
        s.num = s.col;
        s.quo = '0;
        s.rem = '0;
      end
      st_d[j] = s;
    end

    always_ff @(posedge clk_i) begin
      st_q[j] <= st_d[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b1;
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      busy_q  <= 1'b0;
      v_q     <= {v_q[NUM_STAGES-2:0], accept};
      out_v_q <= v_q[NUM_STAGES-1];
    end
  end

  // Output stage: scale placement by stride, shift by pad and kernel offset, check range and image bounds
  always_comb begin
    stage_t f;
    f  = st_q[NUM_STAGES-1];
    px = 17'({4'd0, f.rem} * {13'd0, cfg.s});
    py = 17'({4'd0, f.quo[12:0]} * {13'd0, cfg.s});
    sx = $signed({2'b00, px}) - $signed({15'd0, cfg.p}) + $signed({15'd0, f.dx});
    sy = $signed({2'b00, py}) - $signed({15'd0, cfg.p}) + $signed({15'd0, f.dy});
    in_rng = ({2'b00, f.col} < cfg.xy) && ({1'b0, f.row} < cfg.rowlim);
    in_img = !sx[18] && (sx < $signed({6'd0, cfg.w}))
          && !sy[18] && (sy < $signed({6'd0, cfg.h}));
  end

  always_ff @(posedge clk_i) begin
    in_rng_q <= in_rng;
    in_img_q <= in_rng && in_img;
    sx_q     <= in_rng ? sx[13:0] : 14'sd0;
    sy_q     <= in_rng ? sy[13:0] : 14'sd0;
    dz_q     <= in_rng ? st_q[NUM_STAGES-1].dz : 10'd0;
  end

  assign result_strobe_o  = out_v_q;
  assign source_x_o       = sx_q;
  assign source_y_o       = sy_q;
  assign source_channel_o = dz_q;
  assign inside_image_o   = in_img_q;
  assign index_in_range_o = in_rng_q;

endmodule

### rtl/core/im2col_address_generator_chk.sv
`include "im2col_address_generator_macros.svh"

module im2col_address_generator_chk
  import im2col_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic [23:0]        column_index_i,
  input logic [17:0]        row_index_i,
  input logic               result_strobe_o,
  input logic signed [13:0] source_x_o,
  input logic signed [13:0] source_y_o,
  input logic [9:0]         source_channel_o,
  input logic               inside_image_o,
  input logic               index_in_range_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [2:0]         cfg_index_i,
  input logic [12:0]        cfg_data_i
);

  // each accepted item gives exactly one result, a fixed time later
  `IM2COL_ASSERT_ALWAYS(a_latency, result_strobe_o == $past(start && !busy, LATENCY))
  `IM2COL_ASSERT_IMPL(a_range_zero, result_strobe_o && !index_in_range_o, (source_x_o == 14'sd0) && (source_y_o == 14'sd0) && (source_channel_o == 10'd0) && !inside_image_o)
  `IM2COL_ASSERT_IMPL(a_inside_coords, result_strobe_o && inside_image_o, index_in_range_o && !source_x_o[13] && !source_y_o[13])

endmodule

bind im2col_address_generator im2col_address_generator_chk u_chk (.*);

### test/testbench.sv
`timescale 1ns / 100ps

module testbench
  import im2col_pkg::*;
();

  typedef struct packed {
    logic signed [13:0] sx;
    logic signed [13:0] sy;
    logic [9:0]         ch;
    logic               in_img;
    logic               in_range;
  } point_t;

  class address_board;
    logic [3:0]  kernel = 4'd3;
    logic [3:0]  pad = 4'd1;
    logic [3:0]  stride = 4'd1;
    logic [12:0] width = 13'd32;
    logic [12:0] height = 13'd32;
    logic [10:0] channels = 11'd1;
    point_t      pending[$];
    int          errors = 0;

    function void set_reg(logic [2:0] idx, logic [12:0] data);
      case (idx)
        REG_KERNEL:   kernel = data[3:0];
        REG_PAD:      pad = data[3:0];
        REG_STRIDE:   stride = data[3:0];
        REG_WIDTH:    width = data;
        REG_HEIGHT:   height = data;
        REG_CHANNELS: channels = data[10:0];
        default: ;
      endcase
    endfunction

    function longint eff_k();
      return (kernel == 0) ? 1 : kernel;
    endfunction

    function longint eff_c();
      return (channels == 0) ? 1 : (channels > 1024 ? 1024 : channels);
    endfunction

    function longint fit(longint dim);
      longint d;
      longint padded;
      d = (dim == 0) ? 1 : (dim > 4096 ? 4096 : dim);
      padded = d + 2 * pad;
      if (padded < eff_k()) return 0;
      return (padded - eff_k()) / ((stride == 0) ? 1 : stride) + 1;
    endfunction

    function longint col_count();
      return fit(width) * fit(height);
    endfunction

    function longint row_count();
      return eff_k() * eff_k() * eff_c();
    endfunction

    function void note(logic [23:0] col, logic [17:0] row);
      longint k, s, w, h, xs, dz, sx, sy;
      point_t r;
      k = eff_k();
      s = (stride == 0) ? 1 : stride;
      w = (width == 0) ? 1 : (width > 4096 ? 4096 : width);
      h = (height == 0) ? 1 : (height > 4096 ? 4096 : height);
      xs = fit(width);
      r = '0;
      if (col < col_count() && row < row_count()) begin
        dz = row / (k * k);
        if (dz > eff_c() - 1) dz = eff_c() - 1;
        sx = (col % xs) * s - pad + (row % k);
        sy = (col / xs) * s - pad + ((row / k) % k);
        r.sx = sx[13:0];
        r.sy = sy[13:0];
        r.ch = dz[9:0];
        r.in_img = (sx >= 0 && sx < w && sy >= 0 && sy < h);
        r.in_range = 1'b1;
      end
      pending.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check(point_t got);
      point_t e;
      if (pending.size() == 0) begin
        report("result with nothing outstanding");
        return;
      end
      e = pending.pop_front();
      if (got.sx !== e.sx) report($sformatf("source_x %0d, want %0d", got.sx, e.sx));
      if (got.sy !== e.sy) report($sformatf("source_y %0d, want %0d", got.sy, e.sy));
      if (got.ch !== e.ch) report($sformatf("source_channel %0d, want %0d", got.ch, e.ch));
      if (got.in_img !== e.in_img)
        report($sformatf("inside_image %0b, want %0b", got.in_img, e.in_img));
      if (got.in_range !== e.in_range)
        report($sformatf("index_in_range %0b, want %0b", got.in_range, e.in_range));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [23:0]        column_index_i = '0;
  logic [17:0]        row_index_i = '0;
  logic               result_strobe_o;
  logic signed [13:0] source_x_o;
  logic signed [13:0] source_y_o;
  logic [9:0]         source_channel_o;
  logic               inside_image_o;
  logic               index_in_range_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = REG_KERNEL;
  logic [12:0]        cfg_data_i = '0;

  address_board board = new();
  int items_sent = 0;
  int cycles = 0;

  im2col_address_generator uut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o)
      board.check({source_x_o, source_y_o, source_channel_o, inside_image_o,
                   index_in_range_o});
  end

  task automatic send_item(logic [23:0] col, logic [17:0] row);
    int pct;
    start <= 1'b1;
    column_index_i <= col;
    row_index_i <= row;
    do @(posedge clk_i); while (busy);
    board.note(col, row);
    items_sent++;
    pct = (items_sent < 183) ? 37 : (items_sent < 366 ? 75 : 0);
    // hold off the next item now and then
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [12:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(int k, int p, int s, int w, int h, int c);
    write_reg(REG_KERNEL, 13'(k));
    write_reg(REG_PAD, 13'(p));
    write_reg(REG_STRIDE, 13'(s));
    write_reg(REG_WIDTH, 13'(w));
    write_reg(REG_HEIGHT, 13'(h));
    write_reg(REG_CHANNELS, 13'(c));
    // let derived settings settle
    repeat (8) @(posedge clk_i);
  endtask

  task automatic random_items(int count);
    longint cols, rows;
    logic [23:0] col;
    logic [17:0] row;
    repeat (count) begin
      cols = board.col_count();
      rows = board.row_count();
      col = 24'($urandom);
      row = 18'($urandom);
      if ($urandom_range(99) < 80) begin
        if (cols > 0) col = 24'($urandom_range(cols - 1));
        row = 18'($urandom_range(rows - 1));
      end
      send_item(col, row);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: 32x32, kernel 3, pad 1, 1024 placements, 9 rows
    send_item(24'd0, 18'd0);
    send_item(24'd1023, 18'd8);
    send_item(24'd1024, 18'd0);
    send_item(24'd0, 18'd9);
    send_item(24'hFFFFFF, 18'h3FFFF);
    send_item(24'd31, 18'd2);
    send_item(24'd992, 18'd6);
    send_item(24'd33, 18'd4);
    send_item(24'd31, 18'd8);
    send_item(24'd1023, 18'd0);
    random_items(60);
    drain();

    configure(1, 0, 1, 1, 1, 1);
    send_item(24'd0, 18'd0);
    send_item(24'd1, 18'd0);
    send_item(24'd0, 18'd1);
    random_items(50);
    drain();

    configure(15, 15, 15, 4096, 4096, 1024);
    send_item(24'd0, 18'd0);
    send_item(24'(board.col_count() - 1), 18'(board.row_count() - 1));
    send_item(24'(board.col_count()), 18'd0);
    random_items(80);
    drain();

    // zero kernel and stride, oversized width and channels, zero height
    configure(0, 0, 0, 8191, 0, 2047);
    send_item(24'd4095, 18'd1023);
    send_item(24'd4096, 18'd0);
    random_items(80);
    drain();

    // kernel wider than padded image: nothing is in range
    configure(15, 0, 1, 3, 3, 5);
    send_item(24'd0, 18'd0);
    random_items(40);
    drain();

    configure(4, 2, 3, 100, 57, 7);
    random_items(100);
    drain();

    configure(2, 3, 2, 4096, 4096, 16);
    random_items(110);
    drain();

    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
